// File: src/rti_pkg.sv
// Shared constants and types for the ray/triangle intersection block.
package rti_pkg;

    localparam int CFG_DATA_W = 63;
    localparam int CFG_IDX_W  = 2;
    localparam int DIST_W     = 32;
    localparam int T_FRAC     = 16;
    localparam int SPLIT_W    = 22;
    localparam int EPS_SH0    = 10;
    localparam int EPS_SH1    = 4;
    localparam int EPS_SH2    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_A     = 2'd0,
        CFG_VERTEX_B     = 2'd1,
        CFG_VERTEX_C     = 2'd2,
        CFG_PLANE_NORMAL = 2'd3
    } cfg_idx_t;

endpackage

// File: src/ray_triangle_intersect.sv
// Ray/triangle inside-outside test: one ray per clock through a 43-stage pipeline
// (dot products, epsilon test, 32-stage restoring divider for t, hit point, edge tests).
// The divider makes one quotient bit per stage; throughput is one transaction per cycle.
// The whole pipeline holds while the result waits on m_ready. The user must write triangle
// registers through the cfg port only while no ray is in flight; the block does not enforce it.
module ray_triangle_intersect import rti_pkg::*; #(
    parameter int COORD_BITS = 21
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_origin_x,
    input  logic signed [COORD_BITS-1:0] s_origin_y,
    input  logic signed [COORD_BITS-1:0] s_origin_z,
    input  logic signed [COORD_BITS-1:0] s_dir_x,
    input  logic signed [COORD_BITS-1:0] s_dir_y,
    input  logic signed [COORD_BITS-1:0] s_dir_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic [DIST_W-1:0]            m_distance,
    output logic signed [COORD_BITS-1:0] m_hit_x,
    output logic signed [COORD_BITS-1:0] m_hit_y,
    output logic signed [COORD_BITS-1:0] m_hit_z
);

    localparam int CB    = COORD_BITS;
    localparam int DFW   = CB + 1;
    localparam int PRW   = 2 * CB + 1;
    localparam int NW    = 2 * CB + 3;
    localparam int EPW   = NW + EPS_SH0 + 1;
    localparam int NDIV  = DIST_W;
    localparam int NST   = 4 + NDIV + 7;
    localparam int ODN   = 4 + NDIV + 1;
    localparam int HPW   = CB + DIST_W + 1;
    localparam int SPW   = HPW + 1;
    localparam int EW    = CB + 1;
    localparam int XPW   = 2 * EW;
    localparam int CXW   = XPW + 1;
    localparam int CHW   = CXW - SPLIT_W;
    localparam int PHW   = CHW + CB;
    localparam int PLW   = SPLIT_W + 1 + CB;
    localparam int SHW   = PHW + 2;
    localparam int SLW   = PLW + 2;
    localparam int TTW   = SHW + SPLIT_W + 1;
    localparam logic signed [SPW-1:0] PMAX = SPW'((2 ** (CB - 1)) - 1);
    localparam logic signed [SPW-1:0] PMIN = -PMAX - SPW'(1);

    logic [3*CB-1:0] cfg_a_reg, cfg_b_reg, cfg_c_reg, cfg_n_reg;
    logic [NST-1:0]  vld_reg;
    logic            en;

    logic signed [CB-1:0] vv [3][3];
    logic signed [CB-1:0] vn [3];
    logic signed [CB-1:0] s_o [3];
    logic signed [CB-1:0] s_d [3];

    logic signed [CB-1:0]  odl_o_reg [ODN][3];
    logic signed [CB-1:0]  odl_d_reg [ODN][3];
    logic signed [PRW-1:0] s1_pn_reg [3];
    logic signed [PRW-1:0] s1_pd_reg [3];
    logic signed [NW-1:0]  s2_num_reg, s2_den_reg;
    logic signed [NW-1:0]  s3_nums_reg, s3_aden_reg;
    logic                  s3_dz_reg;

    logic [NW-1:0]     dv_r_reg    [NDIV+1];
    logic [DIST_W-1:0] dv_nb_reg   [NDIV+1];
    logic [DIST_W-1:0] dv_q_reg    [NDIV+1];
    logic [NW-1:0]     dv_aden_reg [NDIV+1];
    logic              dv_sat_reg  [NDIV+1];
    logic              dv_cand_reg [NDIV+1];

    logic signed [HPW-1:0] hp_prod_reg [3];
    logic [DIST_W-1:0]     hp_tq_reg;
    logic                  hp_cand_reg;

    logic signed [CB-1:0]  ep_p_reg  [5][3];
    logic [DIST_W-1:0]     ep_tq_reg [5];
    logic                  ep_cand_reg [5];

    logic signed [XPW-1:0] e1_m_reg [3][6];
    logic signed [CXW-1:0] e2_c_reg [3][3];
    logic signed [PHW-1:0] e3_ph_reg [3][3];
    logic signed [PLW-1:0] e3_pl_reg [3][3];
    logic signed [SHW-1:0] e4_sh_reg [3];
    logic signed [SLW-1:0] e4_sl_reg [3];

    logic                  m_hit_reg;
    logic [DIST_W-1:0]     m_dist_reg;
    logic signed [CB-1:0]  m_p_reg [3];

    logic signed [EW-1:0]  e_c [3][3];
    logic signed [EW-1:0]  w_c [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vv[0][i] = cfg_a_reg[i*CB +: CB];
            vv[1][i] = cfg_b_reg[i*CB +: CB];
            vv[2][i] = cfg_c_reg[i*CB +: CB];
            vn[i]    = cfg_n_reg[i*CB +: CB];
        end
        s_o[0] = s_origin_x;
        s_o[1] = s_origin_y;
        s_o[2] = s_origin_z;
        s_d[0] = s_dir_x;
        s_d[1] = s_dir_y;
        s_d[2] = s_dir_z;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                e_c[j][i] = EW'(vv[(j + 1) % 3][i]) - EW'(vv[j][i]);
                w_c[j][i] = EW'(ep_p_reg[0][i]) - EW'(vv[j][i]);
            end
        end
    end

    assign en        = !vld_reg[NST-1] || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = vld_reg[NST-1];
    assign m_hit      = m_hit_reg;
    assign m_distance = m_dist_reg;
    assign m_hit_x    = m_p_reg[0];
    assign m_hit_y    = m_p_reg[1];
    assign m_hit_z    = m_p_reg[2];

    // triangle registers and valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_a_reg <= '0;
            cfg_b_reg <= '0;
            cfg_c_reg <= '0;
            cfg_n_reg <= '0;
            vld_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_VERTEX_A:     cfg_a_reg <= cfg_data[3*CB-1:0];
                    CFG_VERTEX_B:     cfg_b_reg <= cfg_data[3*CB-1:0];
                    CFG_VERTEX_C:     cfg_c_reg <= cfg_data[3*CB-1:0];
                    CFG_PLANE_NORMAL: cfg_n_reg <= cfg_data[3*CB-1:0];
                    default:          cfg_a_reg <= cfg_a_reg;
                endcase
            end
            if (en) begin
                vld_reg <= {vld_reg[NST-2:0], s_valid};
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        logic [NW:0]           r2;
        logic signed [EPW-1:0] ep;
        logic [DIST_W-1:0]     tq;
        logic signed [SPW-1:0] sv;
        logic signed [CXW-1:0] cc;
        logic signed [CHW-1:0] ch;
        logic signed [TTW-1:0] tot;
        logic                  outside;
        if (en) begin
            // stage 1: products for numerator and denominator
            for (int i = 0; i < 3; i++) begin
                s1_pn_reg[i] <= PRW'(DFW'(vv[0][i]) - DFW'(s_o[i])) * PRW'(vn[i]);
                s1_pd_reg[i] <= PRW'(s_d[i]) * PRW'(vn[i]);
                odl_o_reg[0][i] <= s_o[i];
                odl_d_reg[0][i] <= s_d[i];
            end
            for (int k = 1; k < ODN; k++) begin
                odl_o_reg[k] <= odl_o_reg[k-1];
                odl_d_reg[k] <= odl_d_reg[k-1];
            end
            // stage 2: sums
            s2_num_reg <= NW'(s1_pn_reg[0]) + NW'(s1_pn_reg[1]) + NW'(s1_pn_reg[2]);
            s2_den_reg <= NW'(s1_pd_reg[0]) + NW'(s1_pd_reg[1]) + NW'(s1_pd_reg[2]);
            // stage 3: fold denominator sign into numerator
            s3_nums_reg <= s2_den_reg[NW-1] ? -s2_num_reg : s2_num_reg;
            s3_aden_reg <= s2_den_reg[NW-1] ? -s2_den_reg : s2_den_reg;
            s3_dz_reg   <= (s2_den_reg == '0);
            // stage 4: epsilon test (num*1000 > den), saturation, divider setup
            ep = (EPW'(s3_nums_reg) <<< EPS_SH0) - (EPW'(s3_nums_reg) <<< EPS_SH1)
               - (EPW'(s3_nums_reg) <<< EPS_SH2);
            dv_cand_reg[0] <= !s3_dz_reg && (ep > EPW'(s3_aden_reg));
            dv_sat_reg[0]  <= (s3_nums_reg >>> T_FRAC) >= s3_aden_reg;
            dv_r_reg[0]    <= NW'(s3_nums_reg >>> T_FRAC);
            dv_nb_reg[0]   <= {s3_nums_reg[T_FRAC-1:0], {(DIST_W-T_FRAC){1'b0}}};
            dv_q_reg[0]    <= '0;
            dv_aden_reg[0] <= s3_aden_reg;
            // restoring divider, one quotient bit per stage
            for (int k = 1; k <= NDIV; k++) begin
                r2 = {dv_r_reg[k-1], dv_nb_reg[k-1][DIST_W-1]};
                if (r2 >= {1'b0, dv_aden_reg[k-1]}) begin
                    dv_r_reg[k] <= NW'(r2 - {1'b0, dv_aden_reg[k-1]});
                    dv_q_reg[k] <= {dv_q_reg[k-1][DIST_W-2:0], 1'b1};
                end else begin
                    dv_r_reg[k] <= NW'(r2);
                    dv_q_reg[k] <= {dv_q_reg[k-1][DIST_W-2:0], 1'b0};
                end
                dv_nb_reg[k]   <= {dv_nb_reg[k-1][DIST_W-2:0], 1'b0};
                dv_aden_reg[k] <= dv_aden_reg[k-1];
                dv_sat_reg[k]  <= dv_sat_reg[k-1];
                dv_cand_reg[k] <= dv_cand_reg[k-1];
            end
            // hit point: d * t
            tq = dv_sat_reg[NDIV] ? '1 : dv_q_reg[NDIV];
            for (int i = 0; i < 3; i++) begin
                hp_prod_reg[i] <= HPW'(odl_d_reg[ODN-2][i]) * HPW'($signed({1'b0, tq}));
            end
            hp_tq_reg   <= tq;
            hp_cand_reg <= dv_cand_reg[NDIV];
            // hit point: o + floor(d*t / 2^16), saturated
            for (int i = 0; i < 3; i++) begin
                sv = SPW'(odl_o_reg[ODN-1][i]) + SPW'(hp_prod_reg[i] >>> T_FRAC);
                if (sv > PMAX) begin
                    sv = PMAX;
                end else if (sv < PMIN) begin
                    sv = PMIN;
                end
                ep_p_reg[0][i] <= CB'(sv);
            end
            ep_tq_reg[0]   <= hp_tq_reg;
            ep_cand_reg[0] <= hp_cand_reg;
            for (int k = 1; k < 5; k++) begin
                ep_p_reg[k]    <= ep_p_reg[k-1];
                ep_tq_reg[k]   <= ep_tq_reg[k-1];
                ep_cand_reg[k] <= ep_cand_reg[k-1];
            end
            // edge tests: cross product terms
            for (int j = 0; j < 3; j++) begin
                e1_m_reg[j][0] <= XPW'(e_c[j][1]) * XPW'(w_c[j][2]);
                e1_m_reg[j][1] <= XPW'(e_c[j][2]) * XPW'(w_c[j][1]);
                e1_m_reg[j][2] <= XPW'(e_c[j][2]) * XPW'(w_c[j][0]);
                e1_m_reg[j][3] <= XPW'(e_c[j][0]) * XPW'(w_c[j][2]);
                e1_m_reg[j][4] <= XPW'(e_c[j][0]) * XPW'(w_c[j][1]);
                e1_m_reg[j][5] <= XPW'(e_c[j][1]) * XPW'(w_c[j][0]);
                for (int i = 0; i < 3; i++) begin
                    e2_c_reg[j][i] <= CXW'(e1_m_reg[j][2*i]) - CXW'(e1_m_reg[j][2*i+1]);
                    // split cross component into high and low parts against the normal
                    cc = e2_c_reg[j][i];
                    ch = CHW'(cc >>> SPLIT_W);
                    e3_ph_reg[j][i] <= PHW'(ch) * PHW'(vn[i]);
                    e3_pl_reg[j][i] <= PLW'($signed({1'b0, cc[SPLIT_W-1:0]})) * PLW'(vn[i]);
                end
                e4_sh_reg[j] <= SHW'(e3_ph_reg[j][0]) + SHW'(e3_ph_reg[j][1])
                              + SHW'(e3_ph_reg[j][2]);
                e4_sl_reg[j] <= SLW'(e3_pl_reg[j][0]) + SLW'(e3_pl_reg[j][1])
                              + SLW'(e3_pl_reg[j][2]);
            end
            // output register
            outside = 1'b0;
            for (int j = 0; j < 3; j++) begin
                tot = (TTW'(e4_sh_reg[j]) <<< SPLIT_W) + TTW'(e4_sl_reg[j]);
                outside = outside | tot[TTW-1];
            end
            m_hit_reg <= ep_cand_reg[4] && !outside;
            m_dist_reg <= (ep_cand_reg[4] && !outside) ? ep_tq_reg[4] : '0;
            for (int i = 0; i < 3; i++) begin
                m_p_reg[i] <= (ep_cand_reg[4] && !outside) ? ep_p_reg[4][i] : '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_hit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_distance == '0 && m_hit_x == '0 && m_hit_y == '0
            && m_hit_z == '0)
        else $error("miss result carries nonzero payload");
    a_hit_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_distance != '0)
        else $error("hit with zero distance");
    a_stall_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");
`endif

endmodule

// File: sim/rti_checker.sv
// Checker for the ray/triangle block: predicts each result and compares it.
`timescale 1ns / 1ps
module rti_checker import rti_pkg::*; #(
    parameter int CB = 21
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [CB-1:0]         s_origin_x,
    input  logic [CB-1:0]         s_origin_y,
    input  logic [CB-1:0]         s_origin_z,
    input  logic [CB-1:0]         s_dir_x,
    input  logic [CB-1:0]         s_dir_y,
    input  logic [CB-1:0]         s_dir_z,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_hit,
    input  logic [DIST_W-1:0]     m_distance,
    input  logic [CB-1:0]         m_hit_x,
    input  logic [CB-1:0]         m_hit_y,
    input  logic [CB-1:0]         m_hit_z,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic          hit;
        logic [31:0]   tdist;
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic [CB-1:0] pz;
    } hit_rec_t;

    typedef longint vec3_t [3];

    hit_rec_t       hits_due[$];
    logic [62:0]    tri_reg [4];

    function automatic longint sx(logic [62:0] r, int k);
        logic [CB-1:0] f;
        f = r[k*CB +: CB];
        return longint'($signed(f));
    endfunction

    // c.n < 0, with 128-bit products so nothing overflows
    function automatic bit side_neg(vec3_t v0, vec3_t v1, vec3_t p, vec3_t n);
        logic signed [127:0] e [3];
        logic signed [127:0] w [3];
        logic signed [127:0] s;
        for (int i = 0; i < 3; i++) begin
            e[i] = v1[i] - v0[i];
            w[i] = p[i] - v0[i];
        end
        s = (e[1]*w[2] - e[2]*w[1]) * n[0] + (e[2]*w[0] - e[0]*w[2]) * n[1]
          + (e[0]*w[1] - e[1]*w[0]) * n[2];
        return s < 0;
    endfunction

    function automatic hit_rec_t trace_ray(vec3_t o, vec3_t d);
        hit_rec_t r;
        vec3_t a, b, c, n, p;
        longint num, den, an, ad, v, cmax;
        logic signed [127:0] prod;
        longint unsigned tq;
        bit ok;
        r = '0;
        num = 0;
        den = 0;
        cmax = (longint'(1) <<< (CB-1)) - 1;
        for (int i = 0; i < 3; i++) begin
            a[i] = sx(tri_reg[CFG_VERTEX_A], i);
            b[i] = sx(tri_reg[CFG_VERTEX_B], i);
            c[i] = sx(tri_reg[CFG_VERTEX_C], i);
            n[i] = sx(tri_reg[CFG_PLANE_NORMAL], i);
            num += (a[i] - o[i]) * n[i];
            den += d[i] * n[i];
        end
        if (den == 0) return r;
        ok = den > 0 ? (num * 1000 > den) : (num * 1000 < den);
        if (!ok) return r;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        tq = (an * 65536) / ad;
        if (tq > 64'hFFFF_FFFF) tq = 64'hFFFF_FFFF;
        for (int i = 0; i < 3; i++) begin
            prod = d[i] * $signed({1'b0, tq});
            v = o[i] + longint'(prod >>> 16);
            if (v > cmax) v = cmax;
            if (v < -cmax - 1) v = -cmax - 1;
            p[i] = v;
        end
        if (side_neg(a, b, p, n) || side_neg(b, c, p, n) || side_neg(c, a, p, n))
            return r;
        r.hit = 1'b1;
        r.tdist = tq[31:0];
        r.px = p[0][CB-1:0];
        r.py = p[1][CB-1:0];
        r.pz = p[2][CB-1:0];
        return r;
    endfunction

    assign pending = hits_due.size();

    always @(posedge aclk) begin
        hit_rec_t want, got;
        vec3_t o, d;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) tri_reg[i] <= '0;
            errors <= 0;
        end else begin
            if (cfg_valid && cfg_ready) tri_reg[cfg_index] <= cfg_data;
            if (s_valid && s_ready) begin
                o = '{longint'($signed(s_origin_x)), longint'($signed(s_origin_y)),
                      longint'($signed(s_origin_z))};
                d = '{longint'($signed(s_dir_x)), longint'($signed(s_dir_y)),
                      longint'($signed(s_dir_z))};
                hits_due.push_back(trace_ray(o, d));
            end
            if (m_valid && m_ready) begin
                got = '{m_hit, m_distance, m_hit_x, m_hit_y, m_hit_z};
                if (hits_due.size() == 0) begin
                    if (errors < 10) $display("unexpected result transaction %p", got);
                    errors <= errors + 1;
                end else begin
                    want = hits_due.pop_front();
                    if (want !== got) begin
                        if (errors < 10)
                            $display("mismatch: expected %p, got %p", want, got);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// File: sim/testbench.sv
// Top-level testbench for ray_triangle_intersect: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module testbench;
    import rti_pkg::*;

    localparam int CB = 21;
    localparam int LIMIT = 2000000;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [CB-1:0] s_origin_x = 0, s_origin_y = 0, s_origin_z = 0;
    logic signed [CB-1:0] s_dir_x = 0, s_dir_y = 0, s_dir_z = 0;
    logic m_valid;
    logic m_ready = 0;
    logic m_hit;
    logic [DIST_W-1:0] m_distance;
    logic signed [CB-1:0] m_hit_x, m_hit_y, m_hit_z;
    int errors, pending;
    int send_idle = 0, recv_idle = 0;
    int hold_cycles = 0;
    int cycles = 0;

    ray_triangle_intersect #(.COORD_BITS(CB)) dut (.*);

    rti_checker #(.CB(CB)) chk (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic logic [62:0] pack3(int x, int y, int z);
        logic [CB-1:0] fx, fy, fz;
        fx = CB'(x);
        fy = CB'(y);
        fz = CB'(z);
        return {fz, fy, fx};
    endfunction

    // valid stays high across back-to-back writes; load_triangle lowers it
    task automatic write_reg(cfg_idx_t idx, logic [62:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_triangle(logic [62:0] a, b, c, n);
        write_reg(CFG_VERTEX_A, a);
        write_reg(CFG_VERTEX_B, b);
        write_reg(CFG_VERTEX_C, c);
        write_reg(CFG_PLANE_NORMAL, n);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // valid stays high after acceptance; idling or drain lowers it
    task automatic send_ray(int ox, oy, oz, dx, dy, dz);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_origin_x <= CB'(ox);
        s_origin_y <= CB'(oy);
        s_origin_z <= CB'(oz);
        s_dir_x <= CB'(dx);
        s_dir_y <= CB'(dy);
        s_dir_z <= CB'(dz);
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic int rnd_coord();
        case ($urandom_range(3))
            0: return $urandom_range(2047) - 1024;
            1: return $urandom_range(20479) - 10240;
            default: return int'($signed(CB'($urandom)));
        endcase
    endfunction

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // ray toward a target point on plane z = 0 from above; one in ten is a fully random ray
    task automatic aimed_ray();
        int tx, ty, oz;
        tx = $urandom_range(6000) - 3000;
        ty = $urandom_range(6000) - 3000;
        oz = $urandom_range(20000) + 1;
        if ($urandom_range(9) == 0)
            send_ray(rnd_coord(), rnd_coord(), rnd_coord(),
                     rnd_coord(), rnd_coord(), rnd_coord());
        else
            send_ray(tx + $urandom_range(200) - 100, ty + $urandom_range(200) - 100, oz,
                     $urandom_range(200) - 100, $urandom_range(200) - 100,
                     -int'($urandom_range(4096)));
    endtask

    localparam int MAXC = (1 << (CB-1)) - 1;
    localparam int MINC = -(1 << (CB-1));

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle = 33;
        recv_idle = 45;
        // all-zero registers: zero denominator
        send_ray(0, 0, 0, 1024, 0, 0);
        drain();
        load_triangle(pack3(-2048, -2048, 0), pack3(2048, -2048, 0),
                      pack3(0, 2048, 0), pack3(0, 0, 1024));
        send_ray(0, 0, 1024, 0, 0, -1024);
        send_ray(0, 0, 1024, 0, 0, 1024);
        send_ray(0, 0, 0, 0, 0, -1024);
        send_ray(0, 0, 1, 0, 0, -1024);
        send_ray(0, 0, 2, 0, 0, -1024);
        send_ray(0, 0, 1024, 1024, 0, 0);
        send_ray(5000, 0, 1024, 0, 0, -1024);
        send_ray(-2048, -2048, 1024, 0, 0, -1024);
        send_ray(0, 0, MAXC, 0, 0, -1);
        send_ray(0, 0, MAXC, MAXC, MAXC, -1);
        send_ray(MINC, MINC, MINC, MAXC, MAXC, MAXC);
        send_ray(MAXC, MAXC, MAXC, MINC, MINC, MINC);
        send_ray(0, 0, -1024, 0, 0, -1024);
        drain();
        load_triangle(pack3(MINC, MINC, MAXC), pack3(MAXC, MINC, MINC),
                      pack3(MINC, MAXC, MAXC), pack3(MINC, MAXC, MINC));
        send_ray(0, 0, 0, MAXC, MINC, MAXC);
        send_ray(MAXC, MINC, 0, MINC, MAXC, MINC);
        send_ray(1, 2, 3, -1, -1, -1);
        drain();
        load_triangle(pack3(-3000, -3000, 0), pack3(3000, -3000, 0),
                      pack3(0, 3000, 0), pack3(0, 0, 1024));
        // long receiver stall so the pipeline fills
        hold_cycles = 400;
        for (int k = 0; k < 300; k++) aimed_ray();
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 33 : (ph == 1) ? 45 : 0;
            recv_idle = (ph == 0) ? 45 : (ph == 1) ? 33 : 0;
            for (int k = 0; k < 300; k++) aimed_ray();
            drain();
            if (ph == 0)
                load_triangle(pack3(-3000, -3000, 0), pack3(0, 3000, 0),
                              pack3(3000, -3000, 0), pack3(0, 0, -1024));
            else if (ph == 1)
                load_triangle(63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                              63'({$urandom, $urandom}), 63'({$urandom, $urandom}));
        end
        for (int k = 0; k < 200; k++)
            send_ray(rnd_coord(), rnd_coord(), rnd_coord(),
                     rnd_coord(), rnd_coord(), rnd_coord());
        drain();
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
